/* src/rbd_pkg.sv */
// rbd_pkg: shared types and constants for the ring buffer deque
`default_nettype none
package rbd_pkg;

    // default sizes
    localparam int RING_SLOTS_DEF   = 16;
    localparam int ELEMENT_BITS_DEF = 32;

    // fixed field widths and the capacity reset value
    localparam int CFG_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int CFG_RESET = 15;

    // request codes
    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_POP_FRONT  = 2'd1,
        ACT_PUSH_BACK  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } action_t;

    // result codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // outcome of one request, carried with it down the pipeline
    typedef struct packed {
        logic    pop_ok;
        status_t status;
    } op_info_t;

endpackage
`default_nettype wire

/* src/ring_buffer_deque_core.sv */
// ring_buffer_deque_core: top level of the double-ended queue over a ring ram
//
//  channel | signals                                   | accepted when
//  --------+-------------------------------------------+----------------------------
//  in      | in_valid, in_stall, action, push_value    | in_valid && !in_stall
//  out     | out_valid, out_stall, status, popped_value| out_valid && !out_stall
//  cfg     | cfg_write_en, cfg_write_data              | cfg_write_en
//
// one request per cycle while in_stall is low; a taken request passes through the
// registered ram read and then the output register before its result appears.
// a push writes the ram in the cycle it is taken, so a pop in the next cycle sees it.
// reset empties the deque and sets capacity to 15 (capped by the ring size);
// ram contents are not cleared.
// out_stall backs up through the read stage to in_stall in the same cycle.
`default_nettype none
module ring_buffer_deque_core #(
    parameter int RING_SLOTS   = rbd_pkg::RING_SLOTS_DEF,
    parameter int ELEMENT_BITS = rbd_pkg::ELEMENT_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [1:0]                       action,
    input  wire logic signed [rbd_pkg::VALUE_W-1:0] push_value,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [1:0]                            status,
    output logic signed [rbd_pkg::VALUE_W-1:0]    popped_value,
    input  wire logic                             cfg_write_en,
    input  wire logic [rbd_pkg::CFG_W-1:0]        cfg_write_data
);

    localparam int IDX_W = $clog2(RING_SLOTS);

    logic                    accept;
    logic                    advance;
    rbd_pkg::op_info_t       op;
    logic                    wr_en, rd_en;
    logic [IDX_W-1:0]        wr_addr, rd_addr;
    logic [ELEMENT_BITS-1:0] wr_data, rd_data;
    logic signed [63:0]      push_wide, pop_wide;

    logic                    s1_valid_reg, s1_valid_next;
    rbd_pkg::op_info_t       s1_op_reg;
    logic                    out_valid_reg, out_valid_next;
    rbd_pkg::status_t        out_status_reg;
    logic [rbd_pkg::VALUE_W-1:0] out_value_reg, out_value_next;

    // handshake
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // element width conversion in and out of the ram
    always_comb
    begin
        push_wide = 64'(push_value);
        wr_data   = push_wide[ELEMENT_BITS-1:0];
        pop_wide  = 64'($signed(rd_data));
    end

    rbd_ctrl #(
        .RING_SLOTS (RING_SLOTS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .action         (action),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .op             (op),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr)
    );

    rbd_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (RING_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // read stage and output register occupancy
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
        out_value_next = s1_op_reg.pop_ok ? pop_wide[rbd_pkg::VALUE_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request payload through the read stage into the output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg <= op;
        end
        if (advance && s1_valid_reg)
        begin
            out_status_reg <= s1_op_reg.status;
            out_value_reg  <= out_value_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign popped_value = out_value_reg;

    // checks
    a_stall_only_when_stage_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty read stage");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted request lost before read stage");

    a_refused_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != rbd_pkg::ST_DONE) |-> (out_value_reg == '0))
        else $error("refused request returned a nonzero value");

    a_stalled_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_value_reg)))
        else $error("stalled result changed");

endmodule
`default_nettype wire

/* src/rbd_ram.sv */
// rbd_ram: generic single write port, single read port ram with registered read
`default_nettype none
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* src/rbd_ctrl.sv */
// rbd_ctrl: head, tail and ring size registers, full/empty decision and ram addressing
`default_nettype none
module rbd_ctrl #(
    parameter int RING_SLOTS = rbd_pkg::RING_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [1:0]                    action,
    input  wire logic                          cfg_write_en,
    input  wire logic [rbd_pkg::CFG_W-1:0]     cfg_write_data,
    output rbd_pkg::op_info_t                  op,
    output logic                               wr_en,
    output logic [$clog2(RING_SLOTS)-1:0]      wr_addr,
    output logic                               rd_en,
    output logic [$clog2(RING_SLOTS)-1:0]      rd_addr
);

    localparam int IDX_W      = $clog2(RING_SLOTS);
    localparam int MAX_LAST   = RING_SLOTS - 1;
    localparam int RESET_LAST = (rbd_pkg::CFG_RESET > MAX_LAST) ? MAX_LAST
                                                                : rbd_pkg::CFG_RESET;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] last_reg, last_next;

    logic [IDX_W-1:0] head_up, head_down, tail_up, tail_down;
    rbd_pkg::action_t act;

    assign act = rbd_pkg::action_t'(action);

    // ring neighbors of head and tail, wrapping at the last slot
    always_comb
    begin
        head_up   = (head_reg == last_reg) ? '0 : IDX_W'(head_reg + 1'b1);
        tail_up   = (tail_reg == last_reg) ? '0 : IDX_W'(tail_reg + 1'b1);
        head_down = (head_reg == '0) ? last_reg : IDX_W'(head_reg - 1'b1);
        tail_down = (tail_reg == '0) ? last_reg : IDX_W'(tail_reg - 1'b1);
    end

    // request decode: status, pointer moves and ram access
    always_comb
    begin
        op.pop_ok = 1'b0;
        op.status = rbd_pkg::ST_DONE;
        head_next = head_reg;
        tail_next = tail_reg;
        wr_en     = 1'b0;
        wr_addr   = tail_reg;
        rd_en     = 1'b0;
        rd_addr   = head_reg;
        unique case (act)
            rbd_pkg::ACT_PUSH_FRONT:
            begin
                wr_addr = head_down;
                if (head_down == tail_reg)
                begin
                    op.status = rbd_pkg::ST_FULL;
                end
                else
                begin
                    wr_en     = accept;
                    head_next = head_down;
                end
            end
            rbd_pkg::ACT_POP_FRONT:
            begin
                rd_addr = head_reg;
                if (head_reg == tail_reg)
                begin
                    op.status = rbd_pkg::ST_EMPTY;
                end
                else
                begin
                    op.pop_ok = 1'b1;
                    rd_en     = accept;
                    head_next = head_up;
                end
            end
            rbd_pkg::ACT_PUSH_BACK:
            begin
                wr_addr = tail_reg;
                if (tail_up == head_reg)
                begin
                    op.status = rbd_pkg::ST_FULL;
                end
                else
                begin
                    wr_en     = accept;
                    tail_next = tail_up;
                end
            end
            rbd_pkg::ACT_POP_BACK:
            begin
                rd_addr = tail_down;
                if (head_reg == tail_reg)
                begin
                    op.status = rbd_pkg::ST_EMPTY;
                end
                else
                begin
                    op.pop_ok = 1'b1;
                    rd_en     = accept;
                    tail_next = tail_down;
                end
            end
            default:
            begin
                op.status = rbd_pkg::ST_DONE;
            end
        endcase
    end

    // capacity register holds the last slot index, capped by the ring
    always_comb
    begin
        if (32'(cfg_write_data) > 32'(MAX_LAST))
        begin
            last_next = IDX_W'(MAX_LAST);
        end
        else
        begin
            last_next = IDX_W'(cfg_write_data);
        end
    end

    // pointer update; a capacity write empties the deque
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            last_reg <= IDX_W'(RESET_LAST);
        end
        else if (cfg_write_en)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            last_reg <= last_next;
        end
        else if (accept)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

endmodule
`default_nettype wire

/* verif/ring_buffer_deque_checker.sv */
// ring_buffer_deque_checker: watches the deque channels, predicts each result and compares
module ring_buffer_deque_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [1:0]                         action,
    input  logic signed [rbd_pkg::VALUE_W-1:0] push_value,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [1:0]                         status,
    input  logic signed [rbd_pkg::VALUE_W-1:0] popped_value,
    input  logic                               cfg_write_en,
    input  logic [rbd_pkg::CFG_W-1:0]          cfg_write_data,
    output int                                 fail_count,
    output int                                 outstanding,
    output int                                 results_checked,
    output int                                 pops_returned,
    output int                                 full_refusals,
    output int                                 empty_refusals
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = rbd_pkg::RING_SLOTS_DEF;
    localparam int CAP_W = rbd_pkg::CFG_W;

    // shadow copy of the deque
    logic [rbd_pkg::VALUE_W-1:0] slot_data [SLOTS];
    int unsigned                 front_slot;
    int unsigned                 back_slot;
    logic [rbd_pkg::CFG_W-1:0]   capacity;

    // results still owed by the block, oldest first
    rbd_pkg::status_t            owed_status [$];
    logic [rbd_pkg::VALUE_W-1:0] owed_popped [$];

    // apply one request to the shadow deque and queue the result it must give
    task automatic predict_request(input rbd_pkg::action_t act,
                                   input logic [rbd_pkg::VALUE_W-1:0] val);
        int unsigned                 ring;
        int unsigned                 nxt;
        rbd_pkg::status_t            st;
        logic [rbd_pkg::VALUE_W-1:0] got;
        ring = int'(capacity) + 1;
        if (ring > SLOTS)
            ring = SLOTS;
        st  = rbd_pkg::ST_DONE;
        got = '0;
        case (act)
            rbd_pkg::ACT_PUSH_FRONT:
            begin
                nxt = (front_slot + ring - 1) % ring;
                if (nxt == back_slot)
                    st = rbd_pkg::ST_FULL;
                else
                begin
                    slot_data[nxt] = val;
                    front_slot = nxt;
                end
            end
            rbd_pkg::ACT_POP_FRONT:
            begin
                if (front_slot == back_slot)
                    st = rbd_pkg::ST_EMPTY;
                else
                begin
                    got = slot_data[front_slot];
                    front_slot = (front_slot + 1) % ring;
                end
            end
            rbd_pkg::ACT_PUSH_BACK:
            begin
                nxt = (back_slot + 1) % ring;
                if (nxt == front_slot)
                    st = rbd_pkg::ST_FULL;
                else
                begin
                    slot_data[back_slot] = val;
                    back_slot = nxt;
                end
            end
            default:
            begin
                if (front_slot == back_slot)
                    st = rbd_pkg::ST_EMPTY;
                else
                begin
                    back_slot = (back_slot + ring - 1) % ring;
                    got = slot_data[back_slot];
                end
            end
        endcase
        if (st == rbd_pkg::ST_FULL)
            full_refusals++;
        else if (st == rbd_pkg::ST_EMPTY)
            empty_refusals++;
        else if (act == rbd_pkg::ACT_POP_FRONT || act == rbd_pkg::ACT_POP_BACK)
            pops_returned++;
        owed_status.push_back(st);
        owed_popped.push_back(got);
    endtask

    // sample both channels and the register port at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_slot      = 0;
            back_slot       = 0;
            capacity        = CAP_W'(rbd_pkg::CFG_RESET);
            fail_count      = 0;
            outstanding     = 0;
            results_checked = 0;
            pops_returned   = 0;
            full_refusals   = 0;
            empty_refusals  = 0;
            owed_status.delete();
            owed_popped.delete();
        end
        else
        begin
            // compare a delivered result with the oldest one owed
            if (out_valid && !out_stall)
            begin
                if (owed_status.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with none pending: status %0d popped %0d",
                             $time, status, popped_value);
                end
                else
                begin
                    results_checked++;
                    if (status !== owed_status[0])
                    begin
                        fail_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, owed_status[0], status);
                    end
                    if (popped_value !== owed_popped[0])
                    begin
                        fail_count++;
                        $display("%0t: popped_value expected %0d actual %0d", $time,
                                 $signed(owed_popped[0]), popped_value);
                    end
                    void'(owed_status.pop_front());
                    void'(owed_popped.pop_front());
                end
            end

            // capacity write empties the deque, store keeps its contents
            if (cfg_write_en)
            begin
                capacity   = cfg_write_data;
                front_slot = 0;
                back_slot  = 0;
            end

            if (in_valid && !in_stall)
                predict_request(rbd_pkg::action_t'(action), push_value);

            outstanding = owed_status.size();
        end
    end

endmodule

/* verif/tb_ring_buffer_deque_core.sv */
// tb_ring_buffer_deque_core: stimulus and verdict for the ring buffer deque core
module tb_ring_buffer_deque_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int BLOCK_LEN   = 40;
    localparam int BLOCKS      = 7;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_stall;
    logic [1:0]                         action;
    logic signed [rbd_pkg::VALUE_W-1:0] push_value;
    logic                               out_valid;
    logic                               out_stall;
    logic [1:0]                         status;
    logic signed [rbd_pkg::VALUE_W-1:0] popped_value;
    logic                               cfg_write_en;
    logic [rbd_pkg::CFG_W-1:0]          cfg_write_data;

    int fail_count;
    int outstanding;
    int results_checked;
    int pops_returned;
    int full_refusals;
    int empty_refusals;

    int sender_idle_pct;
    int receiver_stall_pct;
    int requests_sent;
    int capacity_writes;
    int cycle_count;

    ring_buffer_deque_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .push_value     (push_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .popped_value   (popped_value),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    ring_buffer_deque_checker deque_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .push_value      (push_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .popped_value    (popped_value),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .pops_returned   (pops_returned),
        .full_refusals   (full_refusals),
        .empty_refusals  (empty_refusals)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver backpressure
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < receiver_stall_pct);

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, outstanding);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // element value with a bias toward the extremes
    function automatic logic [rbd_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // present one request, with random idle cycles ahead of it
    task automatic issue_request(input rbd_pkg::action_t act,
                                 input logic [rbd_pkg::VALUE_W-1:0] val);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        push_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        requests_sent++;
    endtask

    // hold off until every result is back, then write the capacity
    task automatic set_capacity(input logic [rbd_pkg::CFG_W-1:0] cap);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= cap;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        capacity_writes++;
    endtask

    // one block of random requests: mostly pushes first, then mostly pops
    task automatic random_block(input logic [rbd_pkg::CFG_W-1:0] cap);
        int push_pct;
        set_capacity(cap);
        for (int i = 0; i < BLOCK_LEN; i++)
        begin
            push_pct = (i < 24) ? 90 : 20;
            if ($urandom_range(99) < push_pct)
                issue_request($urandom_range(1) ? rbd_pkg::ACT_PUSH_BACK
                                                : rbd_pkg::ACT_PUSH_FRONT,
                              pick_value());
            else
                issue_request($urandom_range(1) ? rbd_pkg::ACT_POP_BACK
                                                : rbd_pkg::ACT_POP_FRONT,
                              pick_value());
        end
    endtask

    initial
    begin
        logic [rbd_pkg::CFG_W-1:0] cap;
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        action             = rbd_pkg::ACT_PUSH_FRONT;
        push_value         = '0;
        cfg_write_en       = 1'b0;
        cfg_write_data     = '0;
        sender_idle_pct    = 30;
        receiver_stall_pct = 68;
        requests_sent      = 0;
        capacity_writes    = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty pops, extreme values at both ends, reset capacity
        issue_request(rbd_pkg::ACT_POP_FRONT, 32'h1234_5678);
        issue_request(rbd_pkg::ACT_POP_BACK, 32'hdead_beef);
        issue_request(rbd_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
        issue_request(rbd_pkg::ACT_PUSH_BACK, 32'h7fff_ffff);
        issue_request(rbd_pkg::ACT_PUSH_BACK, 32'hffff_ffff);
        issue_request(rbd_pkg::ACT_PUSH_FRONT, 32'h0000_0000);
        issue_request(rbd_pkg::ACT_POP_BACK, 32'h5555_5555);
        issue_request(rbd_pkg::ACT_POP_FRONT, 32'haaaa_aaaa);
        issue_request(rbd_pkg::ACT_POP_FRONT, 32'h0);

        // directed: capacity of one, full refusals at both ends
        set_capacity(4'd1);
        issue_request(rbd_pkg::ACT_PUSH_BACK, 32'h0bad_cafe);
        issue_request(rbd_pkg::ACT_PUSH_FRONT, 32'h1111_1111);
        issue_request(rbd_pkg::ACT_PUSH_BACK, 32'h2222_2222);
        issue_request(rbd_pkg::ACT_POP_FRONT, 32'h0);
        issue_request(rbd_pkg::ACT_POP_BACK, 32'h0);

        // directed: zero capacity refuses everything
        set_capacity(4'd0);
        issue_request(rbd_pkg::ACT_PUSH_FRONT, 32'h3333_3333);
        issue_request(rbd_pkg::ACT_PUSH_BACK, 32'h4444_4444);
        issue_request(rbd_pkg::ACT_POP_FRONT, 32'h0);
        issue_request(rbd_pkg::ACT_POP_BACK, 32'h0);

        // random: three idle mixes, several capacities in each
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct    = (phase == 0) ? 30 : (phase == 1) ? 68 : 0;
            receiver_stall_pct = (phase == 0) ? 68 : (phase == 1) ? 30 : 0;
            for (int blk = 0; blk < BLOCKS; blk++)
            begin
                case (blk)
                    0:       cap = 4'd15;
                    1:       cap = 4'd1;
                    2:       cap = 4'd0;
                    default: cap = 4'($urandom_range(15, 1));
                endcase
                random_block(cap);
            end
        end

        // drain and let the pipeline settle
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("ran %0d requests over %0d capacity writes, %0d results checked",
                 requests_sent, capacity_writes, results_checked);
        $display("%0d pops returned data, %0d pushes refused full, %0d pops refused empty",
                 pops_returned, full_refusals, empty_refusals);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
src/rbd_pkg.sv
src/rbd_ram.sv
src/rbd_ctrl.sv
src/ring_buffer_deque_core.sv
verif/ring_buffer_deque_checker.sv
verif/tb_ring_buffer_deque_core.sv
